// ===== rtl/core/md5_pkg.sv =====
// MD5 stream hash package: function codes, controller command/status structs,
// round constants and helper functions. No dependencies.
package md5_pkg;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_APPEND_FINISH = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word-fill source selection
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN = 2'd3;

  typedef struct packed {
    logic       wr;         // write one byte at fill position
    logic [1:0] src;
    logic       cnt_len;    // add 8 to bit length
    logic       round;      // run one round
    logic       comp_end;   // add working regs into chain
    logic       restart;    // chain, fill, length to initial values
    logic       out_load;   // capture digest for output
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
  } md5_sts_t;

  function automatic logic [31:0] round_add(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    return k[r];
  endfunction

  function automatic logic [4:0] round_shift(input logic [5:0] r);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{r[5:4], r[1:0]}];
  endfunction

  function automatic logic [3:0] word_index(input logic [5:0] r);
    logic [3:0] i;
    unique case (r[5:4])
      2'd0: i = r[3:0];
      2'd1: i = 4'(5 * r[3:0] + 1);
      2'd2: i = 4'(3 * r[3:0] + 5);
      default: i = 4'(7 * r[3:0]);
    endcase
    return i;
  endfunction

endpackage

// ===== rtl/core/md5_stream_hash_core.sv =====
// MD5 stream hash core. Each accepted transfer appends a byte and/or ends the
// message; the unused function code is accepted and ignored. An append that
// fills a block starts a compression (one round per cycle in a single round
// unit). A finish writes padding one byte per cycle up to the end of the block
// and runs a 64-round compression; when fewer than eight bytes were free after
// the 0x80 byte, a second block (zero bytes and the length, 64 rounds) follows.
// The digest is then loaded, and 16 digest bytes go out, low byte of word 0
// first; no new transfer is taken until the digest has drained. Depends on
// md5_pkg, md5_ctrl, md5_dp.
module md5_stream_hash_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] digest_byte,
  output logic       digest_last
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;
  logic              out_busy;

  md5_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .out_busy(out_busy), .cmd(cmd), .sts(sts)
  );

  md5_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .data_byte(data_byte),
    .out_busy(out_busy), .digest_valid(out_valid), .digest_ready(out_ready),
    .digest_byte(digest_byte), .digest_last(digest_last)
  );

endmodule

// ===== rtl/core/md5_ctrl.sv =====
// MD5 controller: accepts transfers, sequences padding, compression and
// digest output. Depends on md5_pkg.
module md5_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic              out_busy,
  output md5_pkg::md5_cmd_t cmd,
  input  md5_pkg::md5_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_PADB = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_LEN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state, state_next;
  logic       fin, fin_next;   // finishing after current compression
  logic       last, last_next; // current compression is the final block
  logic       pad2, pad2_next; // zero/length block follows this compression

  assign in_ready = (state == S_IDLE) && !out_busy;

  always_comb begin
    state_next = state;
    fin_next = fin;
    last_next = last;
    pad2_next = pad2;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          priority if (func == md5_pkg::FUNC_APPEND ||
                       func == md5_pkg::FUNC_APPEND_FINISH) begin
            cmd.wr = 1'b1;
            cmd.src = md5_pkg::SRC_DATA;
            cmd.cnt_len = 1'b1;
            fin_next = (func == md5_pkg::FUNC_APPEND_FINISH);
            last_next = 1'b0;
            if (sts.fill == 6'd63) begin
              state_next = S_COMP;
            end else if (func == md5_pkg::FUNC_APPEND_FINISH) begin
              state_next = S_PADB;
            end
          end else if (func == md5_pkg::FUNC_FINISH) begin
            fin_next = 1'b1;
            last_next = 1'b0;
            state_next = S_PADB;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (sts.rnd == 6'd63) begin
          cmd.comp_end = 1'b1;
          priority if (last) begin
            state_next = S_DONE;
          end else if (fin) begin
            state_next = S_PADB;
          end else if (pad2) begin
            state_next = S_ZERO;
            pad2_next = 1'b0;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PADB: begin
        cmd.wr = 1'b1;
        cmd.src = md5_pkg::SRC_PAD;
        fin_next = 1'b0;
        last_next = 1'b0;
        if (sts.fill == 6'd63) begin
          state_next = S_COMP;
          pad2_next = 1'b1;
        end else begin
          state_next = (sts.fill == 6'd55) ? S_LEN : S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.wr = 1'b1;
        cmd.src = md5_pkg::SRC_ZERO;
        if (sts.fill == 6'd63) begin
          // no room for the length: a second block follows
          state_next = S_COMP;
          pad2_next = 1'b1;
        end else if (sts.fill == 6'd55) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.wr = 1'b1;
        cmd.src = md5_pkg::SRC_LEN;
        if (sts.fill == 6'd63) begin
          state_next = S_COMP;
          last_next = 1'b1;
        end
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        cmd.restart = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
      last <= 1'b0;
      pad2 <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      last <= last_next;
      pad2 <= pad2_next;
    end
  end

`ifndef SYNTHESIS
  a_comp_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && sts.rnd == 6'd63) |=> (state != S_COMP))
    else $error("compression did not end after round 63");
  a_done_from_comp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> $past(state) == S_COMP)
    else $error("digest without compression");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE))
    else $error("ready outside idle");
`endif

endmodule

// ===== rtl/core/md5_dp.sv =====
// MD5 datapath: block buffer, fill count, bit length, chain and working
// registers, one round per cycle, digest output register. Depends on md5_pkg.
module md5_dp (
  input  logic              clk,
  input  logic              rst,
  input  md5_pkg::md5_cmd_t cmd,
  output md5_pkg::md5_sts_t sts,
  input  logic [7:0]        data_byte,
  output logic              out_busy,
  output logic              digest_valid,
  input  logic              digest_ready,
  output logic [7:0]        digest_byte,
  output logic              digest_last
);

  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic        running;
  logic [127:0] dig;
  logic [3:0]  ocnt;
  logic        ovalid;

  logic [7:0]  wbyte;
  logic [31:0] ra, rb, rc, rd, f, t, rot, wsel;
  logic [4:0]  sh;

  assign sts.fill = fill;
  assign sts.rnd = rnd;

  always_comb begin
    unique case (cmd.src)
      md5_pkg::SRC_DATA: wbyte = data_byte;
      md5_pkg::SRC_PAD:  wbyte = md5_pkg::PAD_BYTE;
      md5_pkg::SRC_ZERO: wbyte = 8'h00;
      default:           wbyte = bit_len[{fill[2:0], 3'b000} +: 8];
    endcase
  end

  // first round reads chain words directly
  always_comb begin
    ra = running ? a : ca;
    rb = running ? b : cb;
    rc = running ? c : cc;
    rd = running ? d : cd;
    unique case (rnd[5:4])
      2'd0: f = (rb & rc) | (~rb & rd);
      2'd1: f = (rd & rb) | (~rd & rc);
      2'd2: f = rb ^ rc ^ rd;
      default: f = rc ^ (rb | ~rd);
    endcase
    wsel = w[md5_pkg::word_index(rnd)];
    t = ra + f + md5_pkg::round_add(rnd) + wsel;
    sh = md5_pkg::round_shift(rnd);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) w[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= wbyte;
    if (cmd.round) begin
      a <= rd;
      d <= rc;
      c <= rb;
      b <= rb + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bit_len <= '0;
      rnd <= '0;
      running <= 1'b0;
      ca <= md5_pkg::INIT_A;
      cb <= md5_pkg::INIT_B;
      cc <= md5_pkg::INIT_C;
      cd <= md5_pkg::INIT_D;
    end else begin
      if (cmd.wr) fill <= fill + 6'd1;
      if (cmd.cnt_len) bit_len <= bit_len + 64'd8;
      if (cmd.round) begin
        rnd <= rnd + 6'd1;
        running <= (rnd != 6'd63);
      end
      if (cmd.comp_end) begin
        ca <= ca + rd;
        cb <= cb + rb + rot;
        cc <= cc + rb;
        cd <= cd + rc;
      end
      if (cmd.restart) begin
        fill <= '0;
        bit_len <= '0;
        ca <= md5_pkg::INIT_A;
        cb <= md5_pkg::INIT_B;
        cc <= md5_pkg::INIT_C;
        cd <= md5_pkg::INIT_D;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) dig <= {cd, cc, cb, ca};
    else if (ovalid && digest_ready) dig <= {8'h00, dig[127:8]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      ocnt <= '0;
    end else if (cmd.out_load) begin
      ovalid <= 1'b1;
      ocnt <= '0;
    end else if (ovalid && digest_ready) begin
      ocnt <= ocnt + 4'd1;
      if (ocnt == 4'd15) ovalid <= 1'b0;
    end
  end

  assign digest_valid = ovalid;
  assign digest_byte = dig[7:0];
  assign digest_last = (ocnt == 4'd15);
  // a new digest cannot be loaded while the old one drains
  assign out_busy = ovalid;

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !ovalid)
    else $error("digest overwritten");
  a_wr_not_round: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.round))
    else $error("buffer write during compression");
  a_fill_zero_comp: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> fill == 6'd0)
    else $error("compression with partial block");
`endif

endmodule

// ===== tb/sv/md5_stream_hash_core_tb.sv =====
// Testbench for md5_stream_hash_core: drives message bytes and finishes,
// predicts MD5 digests with its own model, checks every digest byte in order.
// Depends on md5_pkg and md5_stream_hash_core.
`timescale 1ns / 100ps

module md5_stream_hash_core_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class digest_board;
    logic [31:0] chain [4];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [63:0] nbits;
    logic [8:0]  digest_q [$];
    int          errors;
    int          bytes_seen;
    int          digests;

    function void restart();
      chain[0] = md5_pkg::INIT_A; chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C; chain[3] = md5_pkg::INIT_D;
      fill = 0;
      nbits = '0;
    endfunction

    function new();
      restart();
      errors = 0;
      bytes_seen = 0;
      digests = 0;
    endfunction

    function void compress();
      logic [31:0] k [64];
      int          sh [16];
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int          idx, ph, s;
      k = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int r = 0; r < 64; r++) begin
        ph = r / 16;
        case (ph)
          0: begin f = (b & c) | (~b & d); idx = r; end
          1: begin f = (d & b) | (~d & c); idx = (5*r + 1) % 16; end
          2: begin f = b ^ c ^ d; idx = (3*r + 5) % 16; end
          default: begin f = c ^ (b | ~d); idx = (7*r) % 16; end
        endcase
        t = a + f + k[r] + w[idx];
        s = sh[ph*4 + r%4];
        a = d; d = c; c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function void add_byte(logic [7:0] v);
      blk[fill] = v;
      nbits += 64'd8;
      fill++;
      bytes_seen++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void finish();
      logic [63:0] len;
      len = nbits;
      blk[fill] = md5_pkg::PAD_BYTE;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin blk[fill] = 8'h00; fill++; end
        compress();
        fill = 0;
      end
      while (fill < 56) begin blk[fill] = 8'h00; fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = len[8*i +: 8];
      compress();
      for (int i = 0; i < 16; i++)
        digest_q.push_back({i == 15, chain[i/4][8*(i%4) +: 8]});
      digests++;
      restart();
    endfunction

    function void note_input(logic [1:0] fn, logic [7:0] v);
      if (fn == md5_pkg::FUNC_APPEND || fn == md5_pkg::FUNC_APPEND_FINISH) add_byte(v);
      if (fn == md5_pkg::FUNC_APPEND_FINISH || fn == md5_pkg::FUNC_FINISH) finish();
    endfunction

    function void check_output(logic [7:0] db, logic dl);
      logic [8:0] exp_v;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest transfer byte=%h last=%b", $time, db, dl);
        errors++;
        return;
      end
      exp_v = digest_q.pop_front();
      if (db !== exp_v[7:0]) begin
        $display("%0t: digest_byte expected %h actual %h", $time, exp_v[7:0], db);
        errors++;
      end
      if (dl !== exp_v[8]) begin
        $display("%0t: digest_last expected %b actual %b", $time, exp_v[8], dl);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] digest_byte;
  logic       digest_last;

  digest_board board;
  int unsigned cycles;
  bit          quiet;

  md5_stream_hash_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_byte(digest_byte), .digest_last(digest_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // valid stays high into the next transfer when there is no idle gap
  task automatic send(logic [1:0] fn, logic [7:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= v;
    do @(posedge clk); while (!in_ready);
    board.note_input(fn, v);
  endtask

  task automatic send_message(int len, logic [1:0] tail);
    for (int i = 0; i < len; i++) send(md5_pkg::FUNC_APPEND, 8'($urandom));
    if (tail == md5_pkg::FUNC_APPEND_FINISH) send(md5_pkg::FUNC_APPEND_FINISH, 8'($urandom));
    else send(md5_pkg::FUNC_FINISH, 8'($urandom));
  endtask

  // receiver with random stalls
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        board.check_output(digest_byte, digest_last);
        out_ready <= quiet ? 1'b1 : 1'b0;
      end else if (!out_ready) begin
        out_ready <= quiet || ($urandom_range(0, 7) == 0);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int len;
    board     = new();
    quiet     = 1'b0;
    in_valid  = 1'b0;
    func      = md5_pkg::FUNC_APPEND;
    data_byte = 8'h00;
    rst       = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, single byte extremes, unused function code
    send(md5_pkg::FUNC_FINISH, 8'hff);
    send(md5_pkg::FUNC_APPEND_FINISH, 8'h00);
    send(md5_pkg::FUNC_APPEND_FINISH, 8'hff);
    send(FUNC_UNUSED, 8'haa);
    send(md5_pkg::FUNC_APPEND, 8'h55);
    send(FUNC_UNUSED, 8'hff);
    send(md5_pkg::FUNC_FINISH, 8'h00);
    // two-block padding with no idling; full block on append then finish
    quiet = 1'b1;
    send_message(56, md5_pkg::FUNC_FINISH);
    quiet = 1'b0;
    send_message(63, md5_pkg::FUNC_APPEND_FINISH);

    // two short random messages
    repeat (2) begin
      len = $urandom_range(0, 4);
      quiet = ($urandom_range(0, 4) == 0);
      send_message(len, $urandom_range(0, 1) ? md5_pkg::FUNC_APPEND_FINISH
                                             : md5_pkg::FUNC_FINISH);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (board.digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d message bytes and %0d digests, incl. empty and pad edges.",
             board.bytes_seen, board.digests);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
